// ----- rtl/tdq_pkg.sv -----
// ----------------------------------------------------------------------------
// tdq_pkg
// Shared types and constants for the timer deadline queue.
// ----------------------------------------------------------------------------
package tdq_pkg;

  localparam int unsigned DefDepth      = 32;
  localparam int unsigned DefHandleBits = 16;
  localparam int unsigned TimeW         = 48;
  localparam int unsigned IdW           = 16;
  localparam int unsigned ActW          = 2;
  localparam int unsigned StatusW       = 3;
  localparam int unsigned MaxResults    = 32;
  localparam int unsigned FireCntW      = $clog2(MaxResults);

  typedef enum logic [ActW-1:0] {
    ACT_SCHEDULE = 2'd0,
    ACT_CANCEL   = 2'd1,
    ACT_EXPIRE   = 2'd2
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_SCHEDULED = 3'd0,
    ST_REJECTED  = 3'd1,
    ST_CANCELLED = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FIRED     = 3'd4,
    ST_NONE_DUE  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2
  } cell_op_e;

  typedef struct packed {
    cell_op_e         op;
    logic [TimeW-1:0] deadline;
  } cell_cmd_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

endpackage

// ----- rtl/tdq_in_if.sv -----
// ----------------------------------------------------------------------------
// tdq_in_if
// Request channel: schedule, cancel or expire word with valid/ready.
// ----------------------------------------------------------------------------
interface tdq_in_if import tdq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ActW-1:0]  action;
  logic [TimeW-1:0] deadline;
  logic [IdW-1:0]   work_id;
  logic [TimeW-1:0] now_time;

  modport source (output valid, action, deadline, work_id, now_time, input ready);
  modport sink   (input valid, action, deadline, work_id, now_time, output ready);
endinterface

// ----- rtl/tdq_out_if.sv -----
// ----------------------------------------------------------------------------
// tdq_out_if
// Result channel: status, handle and last flag with valid/ready.
// ----------------------------------------------------------------------------
interface tdq_out_if import tdq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [IdW-1:0]     fired_id;
  logic               last;

  modport source (output valid, status, fired_id, last, input ready);
  modport sink   (input valid, status, fired_id, last, output ready);
endinterface

// ----- rtl/tdq_cell.sv -----
// ----------------------------------------------------------------------------
// tdq_cell
// One slot of the sorted timer chain. On insert it keeps its entry, takes the
// new one or takes its lower neighbor's; on remove it takes its upper one's.
// ----------------------------------------------------------------------------
module tdq_cell import tdq_pkg::*; #(
  parameter int unsigned HW = DefHandleBits
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_cmd_t        cmd_i,
  input  logic [HW-1:0]    new_hdl_i,
  input  logic             prev_ins_i,
  input  logic             prev_vld_i,
  input  logic [TimeW-1:0] prev_dl_i,
  input  logic [HW-1:0]    prev_hdl_i,
  input  logic             next_vld_i,
  input  logic [TimeW-1:0] next_dl_i,
  input  logic [HW-1:0]    next_hdl_i,
  input  logic             rm_sel_i,
  output logic             vld_o,
  output logic [TimeW-1:0] dl_o,
  output logic [HW-1:0]    hdl_o,
  output logic             ins_o
);

  logic             vld_q, vld_d;
  logic [TimeW-1:0] dl_q, dl_d;
  logic [HW-1:0]    hdl_q, hdl_d;

  // new entry goes below every later deadline, after equal ones
  assign ins_o = !vld_q || (dl_q > cmd_i.deadline);

  always_comb begin
    vld_d = vld_q;
    dl_d  = dl_q;
    hdl_d = hdl_q;
    case (cmd_i.op)
      CELL_INSERT: begin
        if (ins_o) begin
          if (prev_ins_i) begin
            vld_d = prev_vld_i;
            dl_d  = prev_dl_i;
            hdl_d = prev_hdl_i;
          end else begin
            vld_d = 1'b1;
            dl_d  = cmd_i.deadline;
            hdl_d = new_hdl_i;
          end
        end
      end
      CELL_REMOVE: begin
        if (rm_sel_i) begin
          vld_d = next_vld_i;
          dl_d  = next_dl_i;
          hdl_d = next_hdl_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dl_q  <= dl_d;
    hdl_q <= hdl_d;
  end

  assign vld_o = vld_q;
  assign dl_o  = dl_q;
  assign hdl_o = hdl_q;

endmodule

// ----- rtl/timer_deadline_queue.sv -----
// ----------------------------------------------------------------------------
// timer_deadline_queue
// Bounded timer queue kept sorted by deadline in a chain of cells; equal
// deadlines stay in insertion order. Schedule, cancel by handle, and expire.
// ----------------------------------------------------------------------------
// Sequencing: the request is registered in the idle state and the result word
//   in the execute state; no new request is taken until the last word is
//   loaded. Expire fires one entry per result word (one chain shift per
//   fired word), and any stall on the result channel holds the sequencer.
// Reset: cell valid bits, sequencer and result valid clear at once; entry
//   payload is not reset.
module timer_deadline_queue import tdq_pkg::*; #(
  parameter int unsigned DEPTH       = DefDepth,
  parameter int unsigned HANDLE_BITS = DefHandleBits
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tdq_in_if.sink     in_i,
  tdq_out_if.source  out_o
);

  localparam int unsigned HW = (HANDLE_BITS < IdW) ? HANDLE_BITS : IdW;

  // chain index i+1 holds cell i; index 0 and DEPTH+1 are empty ends
  logic             vld_c [DEPTH+2];
  logic [TimeW-1:0] dl_c  [DEPTH+2];
  logic [HW-1:0]    hdl_c [DEPTH+2];
  logic             ins_c [DEPTH+1];

  state_e               state_q, state_d;
  logic [ActW-1:0]      act_q;
  logic [TimeW-1:0]     dl_q;
  logic [TimeW-1:0]     now_q;
  logic [HW-1:0]        hdl_q;
  logic [FireCntW-1:0]  cnt_q, cnt_d;

  logic                 out_vld_q;
  status_e              status_q, status_d;
  logic [IdW-1:0]       fid_q, fid_d;
  logic                 last_q, last_d;
  logic                 load;

  cell_cmd_t            cmd;
  logic [DEPTH-1:0]     match;
  logic [DEPTH-1:0]     rm_from;
  logic [DEPTH-1:0]     sel;
  logic                 in_acc;
  logic                 slot_free;
  logic                 full;
  logic                 head_due;
  logic                 next_due;

  assign vld_c[0]       = 1'b0;
  assign dl_c[0]        = '0;
  assign hdl_c[0]       = '0;
  assign vld_c[DEPTH+1] = 1'b0;
  assign dl_c[DEPTH+1]  = '0;
  assign hdl_c[DEPTH+1] = '0;
  assign ins_c[0]       = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    tdq_cell #(.HW(HW)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .new_hdl_i  (hdl_q),
      .prev_ins_i (ins_c[i]),
      .prev_vld_i (vld_c[i]),
      .prev_dl_i  (dl_c[i]),
      .prev_hdl_i (hdl_c[i]),
      .next_vld_i (vld_c[i+2]),
      .next_dl_i  (dl_c[i+2]),
      .next_hdl_i (hdl_c[i+2]),
      .rm_sel_i   (sel[i]),
      .vld_o      (vld_c[i+1]),
      .dl_o       (dl_c[i+1]),
      .hdl_o      (hdl_c[i+1]),
      .ins_o      (ins_c[i+1])
    );
    assign match[i] = vld_c[i+1] && (hdl_c[i+1] == hdl_q) && (hdl_q != '0);
  end

  // cells at and above the first match: m | -m
  assign rm_from   = match | (~match + DEPTH'(1));
  assign sel       = (act_q == ACT_EXPIRE) ? '1 : rm_from;

  assign in_acc    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign slot_free = !out_vld_q || out_o.ready;
  assign full      = vld_c[DEPTH];
  assign head_due  = vld_c[1] && (dl_c[1] <= now_q);
  assign next_due  = vld_c[2] && (dl_c[2] <= now_q);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cmd.op       = CELL_HOLD;
    cmd.deadline = dl_q;
    load         = 1'b0;
    status_d     = ST_REJECTED;
    fid_d        = '0;
    last_d       = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_EXEC;
          cnt_d   = '0;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          load    = 1'b1;
          state_d = S_IDLE;
          case (act_q)
            ACT_SCHEDULE: begin
              if (hdl_q != '0 && !full) begin
                cmd.op   = CELL_INSERT;
                status_d = ST_SCHEDULED;
              end
            end
            ACT_CANCEL: begin
              if (|match) begin
                cmd.op   = CELL_REMOVE;
                status_d = ST_CANCELLED;
                fid_d    = IdW'(hdl_q);
              end else begin
                status_d = ST_NOT_FOUND;
              end
            end
            ACT_EXPIRE: begin
              if (head_due) begin
                cmd.op   = CELL_REMOVE;
                status_d = ST_FIRED;
                fid_d    = IdW'(hdl_c[1]);
                last_d   = !next_due || (cnt_q == FireCntW'(MaxResults - 1));
                if (!last_d) begin
                  state_d = S_EXEC;
                  cnt_d   = cnt_q + FireCntW'(1);
                end
              end else begin
                status_d = ST_NONE_DUE;
              end
            end
            default: ;
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q <= in_i.action;
      dl_q  <= in_i.deadline;
      hdl_q <= in_i.work_id[HW-1:0];
      now_q <= in_i.now_time;
    end
    if (load) begin
      status_q <= status_d;
      fid_q    <= fid_d;
      last_q   <= last_d;
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.status   = status_q;
  assign out_o.fired_id = fid_q;
  assign out_o.last     = last_q;

endmodule

// ----- rtl/tdq_checker.sv -----
// ----------------------------------------------------------------------------
// tdq_checker
// Port-level checks for the timer deadline queue, bound to the top level.
// ----------------------------------------------------------------------------
module tdq_checker import tdq_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [StatusW-1:0] status_i,
  input logic [IdW-1:0]     fired_id_i,
  input logic               last_i
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
      $stable(fired_id_i) && $stable(last_i))
    else $error("result word changed while stalled");

  // one request in flight at a time
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while previous one in flight");

  // no new request while an expire burst is still going
  a_burst_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_i |-> !in_ready_i)
    else $error("request ready during expire burst");

  // only fired and cancelled words carry a handle
  a_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_FIRED && status_i != ST_CANCELLED |-> fired_id_i == '0)
    else $error("handle on word that carries none");

  // everything but a fired word is a single-word answer
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_FIRED |-> last_i)
    else $error("non-fired word without last");

endmodule

bind timer_deadline_queue tdq_checker u_tdq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .status_i    (out_o.status),
  .fired_id_i  (out_o.fired_id),
  .last_i      (out_o.last)
);
